[hw/rtl/i2c_master_byte_engine_defines.svh]
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// same-cycle implication
`define I2CME_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define I2CME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hw/rtl/i2cme_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, engine phases, queue item and engine state types, and the
// phase entry and segment advance functions.
// ----------------------------------------------------------------------------
package i2cme_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_PROBE = 3'd5
  } i2cme_op_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_WR_SET  = 4'd5,
    PH_WR_HI   = 4'd6,
    PH_WR_LO   = 4'd7,
    PH_AK_REL  = 4'd8,
    PH_AK_HI   = 4'd9,
    PH_AK_POLL = 4'd10,
    PH_RD_LO   = 4'd11,
    PH_RD_HI   = 4'd12,
    PH_RA_LO   = 4'd13,
    PH_RA_HI   = 4'd14
  } i2cme_phase_e;

  localparam logic [3:0] BitsPerByte = 4'd8;
  localparam logic [7:0] MsbMask     = 8'h80;

  localparam logic [0:0] CfgHalfPeriod = 1'b0;
  localparam logic [0:0] CfgAckTimeout = 1'b1;

  localparam logic [15:0] HalfPeriodRst = 16'd100;
  localparam logic [7:0]  AckTimeoutRst = 8'd250;

  typedef struct packed {
    i2cme_op_e  op;
    logic [7:0] data;
    logic       ack;
    logic       sda;
  } i2cme_cmd_t;

  typedef struct packed {
    i2cme_phase_e phase;
    logic [3:0]   bit_index;
    logic [7:0]   shift_byte;
    logic [15:0]  tick_count;
    logic [7:0]   timeout_count;
    logic         scl_level;
    logic         sda_low;
    logic         pending_ack;
    logic         probe_mode;
    logic         nack_flag;
    logic [7:0]   read_reg;
    logic         done;
  } i2cme_state_t;

  function automatic i2cme_state_t enter_phase(i2cme_state_t s, i2cme_phase_e p);
    i2cme_state_t r;
    r = s;
    r.phase = p;
    r.tick_count = '0;
    unique case (p)
      PH_ST_A: begin
        r.scl_level = 1'b1;
        r.sda_low   = 1'b0;
      end
      PH_ST_B: r.sda_low = 1'b1;
      PH_SP_A: begin
        r.scl_level = 1'b0;
        r.sda_low   = 1'b1;
      end
      PH_SP_B: begin
        r.scl_level = 1'b1;
        r.sda_low   = 1'b0;
      end
      PH_WR_SET: begin
        r.scl_level = 1'b0;
        r.sda_low   = ((r.shift_byte & MsbMask) == 8'h00);
      end
      PH_WR_HI: r.scl_level = 1'b1;
      PH_WR_LO: r.scl_level = 1'b0;
      PH_AK_REL: begin
        r.scl_level     = 1'b0;
        r.sda_low       = 1'b0;
        r.timeout_count = '0;
      end
      PH_AK_HI: r.scl_level = 1'b1;
      PH_RD_LO: begin
        r.scl_level = 1'b0;
        r.sda_low   = 1'b0;
      end
      PH_RD_HI: r.scl_level = 1'b1;
      PH_RA_LO: begin
        r.scl_level = 1'b0;
        r.sda_low   = r.pending_ack;
      end
      PH_RA_HI: r.scl_level = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic i2cme_state_t finish_cmd(i2cme_state_t s);
    i2cme_state_t r;
    r = s;
    r.phase = PH_IDLE;
    r.tick_count = '0;
    r.done = 1'b1;
    return r;
  endfunction

  // end of a segment
  function automatic i2cme_state_t advance(i2cme_state_t s, logic sda);
    i2cme_state_t r;
    r = s;
    unique case (s.phase)
      PH_ST_A: r = enter_phase(r, PH_ST_B);
      PH_ST_B: begin
        r.scl_level = 1'b0;
        if (r.probe_mode) begin
          r = enter_phase(r, PH_WR_SET);
        end else begin
          r = finish_cmd(r);
        end
      end
      PH_SP_A:   r = enter_phase(r, PH_SP_B);
      PH_SP_B:   r = finish_cmd(r);
      PH_WR_SET: r = enter_phase(r, PH_WR_HI);
      PH_WR_HI:  r = enter_phase(r, PH_WR_LO);
      PH_WR_LO: begin
        r.shift_byte = {r.shift_byte[6:0], 1'b0};
        r.bit_index  = r.bit_index + 4'd1;
        if (r.bit_index < BitsPerByte) begin
          r = enter_phase(r, PH_WR_SET);
        end else begin
          r = enter_phase(r, PH_AK_REL);
        end
      end
      PH_AK_REL: r = enter_phase(r, PH_AK_HI);
      PH_AK_HI:  r = enter_phase(r, PH_AK_POLL);
      PH_RD_LO:  r = enter_phase(r, PH_RD_HI);
      PH_RD_HI: begin
        r.shift_byte = {r.shift_byte[6:0], sda};
        r.bit_index  = r.bit_index + 4'd1;
        if (r.bit_index < BitsPerByte) begin
          r = enter_phase(r, PH_RD_LO);
        end else begin
          r.read_reg = r.shift_byte;
          r = enter_phase(r, PH_RA_LO);
        end
      end
      PH_RA_LO: r = enter_phase(r, PH_RA_HI);
      PH_RA_HI: begin
        r.scl_level = 1'b0;
        r = finish_cmd(r);
      end
      default: r = finish_cmd(r);
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/i2cme_front.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine front end
// Accepts input ticks, maps the operation to a command code and queues the
// tick for the engine.
// ----------------------------------------------------------------------------
module i2cme_front
  import i2cme_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic       ack_after_read_i,
  input  logic       sda_in_i,
  output logic       cmd_valid_o,
  output i2cme_cmd_t cmd_o,
  input  logic       cmd_pop_i
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  i2cme_cmd_t          queue_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push;
  i2cme_cmd_t          item;

  always_comb begin
    item.data = data_byte_i;
    item.ack  = ack_after_read_i;
    item.sda  = sda_in_i;
    unique case (operation_i)
      OP_START: item.op = OP_START;
      OP_STOP:  item.op = OP_STOP;
      OP_WRITE: item.op = OP_WRITE;
      OP_READ:  item.op = OP_READ;
      OP_PROBE: item.op = OP_PROBE;
      default:  item.op = OP_IDLE;
    endcase
  end

  assign in_stall_o  = (count_q == CntW'(QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (push && !cmd_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item;
    end
  end

endmodule

[hw/rtl/i2cme_back.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine back end
// Runs one engine tick per queued item, holds the configuration registers
// and registers the line levels and status for the output channel.
// ----------------------------------------------------------------------------
module i2cme_back
  import i2cme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        cmd_valid_i,
  input  i2cme_cmd_t  cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_pull_low_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        nack_o
);

  logic [15:0]  half_period_q;
  logic [7:0]   ack_timeout_q;
  logic [15:0]  hp;
  i2cme_state_t state_q, state_d;
  logic         out_valid_q, out_valid_d;

  assign hp        = (half_period_q == '0) ? 16'd1 : half_period_q;
  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    state_d.done = 1'b0;
    if (state_d.phase == PH_IDLE && cmd_i.op != OP_IDLE) begin
      state_d.probe_mode = 1'b0;
      state_d.bit_index  = '0;
      unique case (cmd_i.op)
        OP_START: state_d = enter_phase(state_d, PH_ST_A);
        OP_STOP:  state_d = enter_phase(state_d, PH_SP_A);
        OP_WRITE: begin
          state_d.nack_flag  = 1'b0;
          state_d.shift_byte = cmd_i.data;
          state_d = enter_phase(state_d, PH_WR_SET);
        end
        OP_READ: begin
          state_d.pending_ack = cmd_i.ack;
          state_d.shift_byte  = '0;
          state_d = enter_phase(state_d, PH_RD_LO);
        end
        default: begin
          state_d.nack_flag  = 1'b0;
          state_d.probe_mode = 1'b1;
          state_d.shift_byte = cmd_i.data;
          state_d = enter_phase(state_d, PH_ST_A);
        end
      endcase
    end

    priority if (state_d.phase == PH_AK_POLL) begin
      priority if (!cmd_i.sda) begin
        state_d.scl_level = 1'b0;
        if (state_d.probe_mode) begin
          state_d = enter_phase(state_d, PH_SP_A);
        end else begin
          state_d = finish_cmd(state_d);
        end
      end else if (state_d.timeout_count >= ack_timeout_q) begin
        state_d.nack_flag = 1'b1;
        state_d = enter_phase(state_d, PH_SP_A);
      end else begin
        state_d.timeout_count = state_d.timeout_count + 8'd1;
      end
    end else if (state_d.phase != PH_IDLE) begin
      state_d.tick_count = state_d.tick_count + 16'd1;
      if (state_d.tick_count >= hp) begin
        state_d = advance(state_d, cmd_i.sda);
      end
    end else begin
      state_d.tick_count = state_d.tick_count;
    end
  end

  always_comb begin
    priority if (cmd_pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfPeriod: half_period_q <= cfg_wdata_i;
        default:       ack_timeout_q <= cfg_wdata_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_IDLE;
      state_q.bit_index     <= '0;
      state_q.shift_byte    <= '0;
      state_q.tick_count    <= '0;
      state_q.timeout_count <= '0;
      state_q.scl_level     <= 1'b1;
      state_q.sda_low       <= 1'b0;
      state_q.pending_ack   <= 1'b0;
      state_q.probe_mode    <= 1'b0;
      state_q.nack_flag     <= 1'b0;
      state_q.read_reg      <= '0;
      state_q.done          <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_pop_o) begin
        state_q <= state_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_out_o      = state_q.scl_level;
  assign sda_pull_low_o = state_q.sda_low;
  assign busy_res_o     = (state_q.phase != PH_IDLE);
  assign done_res_o     = state_q.done;
  assign read_data_o    = state_q.read_reg;
  assign nack_o         = state_q.nack_flag;

endmodule

[hw/rtl/i2c_master_byte_engine.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine
// I2C master stepped once per input transfer: start, stop, write byte with
// ACK wait, read byte with ACK/NACK, device probe.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transfer is one engine tick,
//   carrying an optional command plus the sampled SDA level.
//   Output channel (out_valid_o / out_stall_i): exactly one result transfer per
//   input transfer, in order: SCL level, SDA pull-low, busy, done pulse, last
//   read byte and NACK flag after that tick.
//   Path: an accepted input is written into the queue, then taken by the
//   engine update into the output register; an output stall can hold it between.
//   Throughput: one tick per cycle while the output is not stalled.
//   Config: cfg_we_i writes register cfg_idx_i (0 half period ticks,
//   1 ACK timeout count); write only with no transfer in flight.
//   Reset: engine idle, SCL released, SDA released, half period 100, ACK
//   timeout 250, queue and output empty.
//   Output stall: the result holds; the two-entry queue keeps taking input
//   until full, then in_stall_o rises.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
  import i2cme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        ack_after_read_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_pull_low_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        nack_o
);

  logic       cmd_valid;
  logic       cmd_pop;
  i2cme_cmd_t cmd;

  i2cme_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .ack_after_read_i (ack_after_read_i),
    .sda_in_i         (sda_in_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  i2cme_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_out_o      (scl_out_o),
    .sda_pull_low_o (sda_pull_low_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_data_o    (read_data_o),
    .nack_o         (nack_o)
  );

endmodule

[hw/rtl/i2cme_checker.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine checker
// Port-level checks on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_defines.svh"

module i2cme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        scl_out_o,
  input logic        sda_pull_low_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic [7:0]  read_data_o,
  input logic        nack_o
);

  // a completing tick leaves the engine idle
  `I2CME_ASSERT_NOW(a_done_not_busy, out_valid_o && done_res_o, !busy_res_o)

  // every command spans at least two ticks, so done never repeats back to back
  `I2CME_ASSERT_NEXT(a_done_single, out_valid_o && !out_stall_i && done_res_o,
                     !(out_valid_o && done_res_o))

  // a stalled result holds
  `I2CME_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                     out_valid_o && $stable(scl_out_o) && $stable(sda_pull_low_o) &&
                     $stable(done_res_o) && $stable(read_data_o) && $stable(nack_o))

endmodule

bind i2c_master_byte_engine i2cme_checker u_checker (.*);
